@@ rtl/core/bmpd_pkg.sv @@
// shared types and constants of the bmp stream decoder
`default_nettype none
package bmpd_pkg;

    // image size limits
    localparam int unsigned MAX_WIDTH  = 4096;
    localparam int unsigned MAX_HEIGHT = 4096;

    // fixed field widths of the result transaction and of the parser counters
    localparam int unsigned DIM_W   = 13;
    localparam int unsigned COORD_W = 12;
    localparam int unsigned COUNT_W = 13;

    // result queue between parser and output stage
    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // header byte positions
    localparam logic [31:0] POS_SIG_B       = 32'd0;
    localparam logic [31:0] POS_SIG_M       = 32'd1;
    localparam logic [31:0] POS_OFFSET      = 32'd13;
    localparam logic [31:0] POS_INFO_SIZE   = 32'd17;
    localparam logic [31:0] POS_WIDTH       = 32'd21;
    localparam logic [31:0] POS_HEIGHT      = 32'd25;
    localparam logic [31:0] POS_PLANES      = 32'd27;
    localparam logic [31:0] POS_BPP         = 32'd29;
    localparam logic [31:0] POS_COMPRESSION = 32'd33;
    localparam logic [31:0] POS_HEADER_END  = 32'd53;
    localparam logic [31:0] PIXEL_START     = 32'd54;

    localparam logic [7:0]  CHAR_B        = 8'h42;
    localparam logic [7:0]  CHAR_M        = 8'h4D;
    localparam logic [31:0] MIN_INFO_SIZE = 32'd40;
    localparam logic [15:0] BPP_24        = 16'd24;
    localparam logic [15:0] BPP_32        = 16'd32;
    localparam logic [15:0] ONE_PLANE     = 16'd1;
    localparam logic [7:0]  ALPHA_OPAQUE  = 8'd255;

    // format check flag bits
    localparam int unsigned FLAG_SIG    = 0;
    localparam int unsigned FLAG_INFO   = 1;
    localparam int unsigned FLAG_PLANES = 2;
    localparam int unsigned FLAG_BPP    = 3;

    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_ERROR  = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ERR_SIGNATURE = 3'd0,
        ERR_INFO_SIZE = 3'd1,
        ERR_FORMAT    = 3'd2,
        ERR_SIZE_ZERO = 3'd3,
        ERR_OFFSET    = 3'd4,
        ERR_TOO_LARGE = 3'd5,
        ERR_TRUNCATED = 3'd6
    } err_t;

    // one queued result, before output formatting
    typedef struct packed {
        kind_t              kind;
        err_t               err;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         last_byte;
        logic               wide;
        logic               bottom_up;
    } entry_t;

endpackage
`default_nettype wire

@@ rtl/core/bmpd_front.sv @@
// byte parser: header fields, checks, pixel assembly and row padding
`default_nettype none
module bmpd_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           accept,
    input  wire logic [7:0]     data_byte,
    input  wire logic           end_of_file,
    output bmpd_pkg::entry_t    entry,
    output logic                push
);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_PIXELS,
        PH_PAD,
        PH_DONE,
        PH_ERROR
    } phase_t;

    phase_t                         phase_reg, phase_next;
    logic [31:0]                    pos_reg, pos_next;
    logic [31:0]                    shift_reg, shift_next;
    logic [31:0]                    offset_reg, offset_next;
    logic [31:0]                    width_reg, width_next;
    logic [31:0]                    height_reg, height_next;
    logic [3:0]                     flags_reg, flags_next;
    logic                           wide_reg, wide_next;
    logic                           bottom_up_reg, bottom_up_next;
    logic [bmpd_pkg::COUNT_W-1:0]   col_reg, col_next;
    logic [bmpd_pkg::COUNT_W-1:0]   row_reg, row_next;
    logic [1:0]                     bip_reg, bip_next;
    logic [1:0]                     pad_reg, pad_next;
    logic [23:0]                    held_reg, held_next;

    logic [15:0]                    half;
    logic [31:0]                    height_abs;
    logic [1:0]                     last_idx;
    logic [1:0]                     row_pad;
    logic [bmpd_pkg::COUNT_W-1:0]   col_inc;
    logic [bmpd_pkg::COUNT_W-1:0]   row_inc;
    logic [bmpd_pkg::DIM_W-1:0]     width_dim;
    logic [bmpd_pkg::DIM_W-1:0]     height_dim;

    assign width_dim  = width_reg[bmpd_pkg::DIM_W-1:0];
    assign height_dim = height_reg[bmpd_pkg::DIM_W-1:0];
    assign height_abs = height_reg[31] ? (32'd0 - height_reg) : height_reg;
    assign last_idx   = wide_reg ? 2'd3 : 2'd2;
    assign col_inc    = col_reg + 1'b1;
    assign row_inc    = row_reg + 1'b1;
    assign row_pad    = wide_reg ? 2'd0 : width_reg[1:0];

    always_comb begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        shift_next     = shift_reg;
        offset_next    = offset_reg;
        width_next     = width_reg;
        height_next    = height_reg;
        flags_next     = flags_reg;
        wide_next      = wide_reg;
        bottom_up_next = bottom_up_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        bip_next       = bip_reg;
        pad_next       = pad_reg;
        held_next      = held_reg;
        half           = shift_reg[31:16];
        push           = 1'b0;
        entry          = '0;

        if (accept) begin
            case (phase_reg)
                PH_HEADER: begin
                    shift_next = {data_byte, shift_reg[31:8]};
                    half       = shift_next[31:16];
                    if (pos_reg == bmpd_pkg::POS_SIG_B && data_byte == bmpd_pkg::CHAR_B) begin
                        flags_next[bmpd_pkg::FLAG_SIG] = 1'b1;
                    end
                    if (pos_reg == bmpd_pkg::POS_SIG_M && data_byte != bmpd_pkg::CHAR_M) begin
                        flags_next[bmpd_pkg::FLAG_SIG] = 1'b0;
                    end
                    if (pos_reg == bmpd_pkg::POS_OFFSET) begin
                        offset_next = shift_next;
                    end
                    if (pos_reg == bmpd_pkg::POS_INFO_SIZE
                        && shift_next >= bmpd_pkg::MIN_INFO_SIZE) begin
                        flags_next[bmpd_pkg::FLAG_INFO] = 1'b1;
                    end
                    if (pos_reg == bmpd_pkg::POS_WIDTH) begin
                        width_next = shift_next;
                    end
                    if (pos_reg == bmpd_pkg::POS_HEIGHT) begin
                        height_next = shift_next;
                    end
                    if (pos_reg == bmpd_pkg::POS_PLANES && half == bmpd_pkg::ONE_PLANE) begin
                        flags_next[bmpd_pkg::FLAG_PLANES] = 1'b1;
                    end
                    if (pos_reg == bmpd_pkg::POS_BPP) begin
                        if (half == bmpd_pkg::BPP_24 || half == bmpd_pkg::BPP_32) begin
                            flags_next[bmpd_pkg::FLAG_BPP] = 1'b1;
                        end
                        wide_next = (half == bmpd_pkg::BPP_32);
                    end
                    if (pos_reg == bmpd_pkg::POS_COMPRESSION && shift_next != 32'd0) begin
                        flags_next[bmpd_pkg::FLAG_PLANES] = 1'b0;
                    end

                    if (pos_reg != bmpd_pkg::POS_HEADER_END) begin
                        pos_next = pos_reg + 32'd1;
                    end else begin
                        // end of info header: decide accept or reject
                        bottom_up_next = ~height_reg[31];
                        height_next    = height_abs;
                        push           = 1'b1;
                        entry.kind     = bmpd_pkg::KIND_ERROR;
                        phase_next     = PH_ERROR;
                        if (!flags_reg[bmpd_pkg::FLAG_SIG]) begin
                            entry.err = bmpd_pkg::ERR_SIGNATURE;
                        end else if (!flags_reg[bmpd_pkg::FLAG_INFO]) begin
                            entry.err = bmpd_pkg::ERR_INFO_SIZE;
                        end else if (!flags_reg[bmpd_pkg::FLAG_PLANES]
                                     || !flags_reg[bmpd_pkg::FLAG_BPP]) begin
                            entry.err = bmpd_pkg::ERR_FORMAT;
                        end else if (width_reg == 32'd0 || width_reg[31]
                                     || height_abs == 32'd0) begin
                            entry.err = bmpd_pkg::ERR_SIZE_ZERO;
                        end else if (offset_reg < bmpd_pkg::PIXEL_START) begin
                            entry.err = bmpd_pkg::ERR_OFFSET;
                        end else if (width_reg > 32'(bmpd_pkg::MAX_WIDTH)
                                     || height_abs > 32'(bmpd_pkg::MAX_HEIGHT)) begin
                            entry.err = bmpd_pkg::ERR_TOO_LARGE;
                        end else begin
                            entry.kind   = bmpd_pkg::KIND_HEADER;
                            entry.width  = width_dim;
                            entry.height = height_abs[bmpd_pkg::DIM_W-1:0];
                            pos_next     = bmpd_pkg::PIXEL_START;
                            col_next     = '0;
                            row_next     = '0;
                            bip_next     = '0;
                            pad_next     = '0;
                            held_next    = '0;
                            phase_next   = (offset_reg == bmpd_pkg::PIXEL_START)
                                           ? PH_PIXELS : PH_SKIP;
                        end
                    end
                end
                PH_SKIP: begin
                    pos_next = pos_reg + 32'd1;
                    if (pos_next >= offset_reg) begin
                        phase_next = PH_PIXELS;
                    end
                end
                PH_PIXELS: begin
                    case (bip_reg)
                        2'd0:    held_next = {16'd0, data_byte};
                        2'd1:    held_next[15:8] = data_byte;
                        2'd2:    held_next[23:16] = data_byte;
                        default: held_next = held_reg;
                    endcase
                    if (bip_reg != last_idx) begin
                        bip_next = bip_reg + 2'd1;
                    end else begin
                        bip_next        = '0;
                        push            = 1'b1;
                        entry.kind      = bmpd_pkg::KIND_PIXEL;
                        entry.width     = width_dim;
                        entry.height    = height_dim;
                        entry.col       = col_reg[bmpd_pkg::COORD_W-1:0];
                        entry.row       = row_reg[bmpd_pkg::COORD_W-1:0];
                        entry.red       = held_next[23:16];
                        entry.green     = held_next[15:8];
                        entry.blue      = held_next[7:0];
                        entry.last_byte = data_byte;
                        entry.wide      = wide_reg;
                        entry.bottom_up = bottom_up_reg;
                        col_next        = col_inc;
                        if (col_inc == width_dim) begin
                            if (row_pad != 2'd0) begin
                                pad_next   = row_pad;
                                phase_next = PH_PAD;
                            end else begin
                                col_next = '0;
                                row_next = row_inc;
                                if (row_inc == height_dim) begin
                                    phase_next = PH_DONE;
                                end
                            end
                        end
                    end
                end
                PH_PAD: begin
                    pad_next = pad_reg - 2'd1;
                    if (pad_next == 2'd0) begin
                        phase_next = PH_PIXELS;
                        col_next   = '0;
                        row_next   = row_inc;
                        if (row_inc == height_dim) begin
                            phase_next = PH_DONE;
                        end
                    end
                end
                default: begin
                end
            endcase

            if (end_of_file) begin
                if (phase_next != PH_DONE && phase_next != PH_ERROR) begin
                    push       = 1'b1;
                    entry      = '0;
                    entry.kind = bmpd_pkg::KIND_ERROR;
                    entry.err  = bmpd_pkg::ERR_TRUNCATED;
                end
                phase_next = PH_HEADER;
                pos_next   = '0;
                flags_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_HEADER;
            pos_reg   <= '0;
            flags_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            flags_reg <= flags_next;
        end
        shift_reg     <= shift_next;
        offset_reg    <= offset_next;
        width_reg     <= width_next;
        height_reg    <= height_next;
        wide_reg      <= wide_next;
        bottom_up_reg <= bottom_up_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        bip_reg       <= bip_next;
        pad_reg       <= pad_next;
        held_reg      <= held_next;
    end

endmodule
`default_nettype wire

@@ rtl/core/bmpd_queue.sv @@
// short result queue between the parser and the output stage
`default_nettype none
module bmpd_queue (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               push,
    input  wire bmpd_pkg::entry_t   push_entry,
    input  wire logic               pop,
    output bmpd_pkg::entry_t        head,
    output logic                    head_valid,
    output logic                    full
);

    bmpd_pkg::entry_t                   slots_reg [bmpd_pkg::QUEUE_DEPTH];
    logic [bmpd_pkg::QPTR_W-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [bmpd_pkg::QPTR_W-1:0]        rd_ptr_reg, rd_ptr_next;
    logic [bmpd_pkg::QCNT_W-1:0]        count_reg, count_next;
    logic                               do_pop;

    localparam logic [bmpd_pkg::QPTR_W-1:0] LAST_SLOT =
        bmpd_pkg::QPTR_W'(bmpd_pkg::QUEUE_DEPTH - 1);

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == bmpd_pkg::QCNT_W'(bmpd_pkg::QUEUE_DEPTH));
    assign head       = slots_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule
`default_nettype wire

@@ rtl/core/bmpd_back.sv @@
// output stage: row flip, alpha fill, last pixel flag and result register
`default_nettype none
module bmpd_back (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire bmpd_pkg::entry_t   head,
    input  wire logic               head_valid,
    output logic                    pop,
    output logic                    m_tvalid,
    input  wire logic               m_tready,
    output logic [87:0]             m_tdata,
    output logic [1:0]              m_tuser,
    output logic                    m_tlast
);

    logic                               valid_reg, valid_next;
    logic [87:0]                        data_reg, data_next;
    logic [1:0]                         user_reg, user_next;
    logic                               last_reg, last_next;
    logic [bmpd_pkg::COORD_W-1:0]       pixel_y;
    logic [bmpd_pkg::DIM_W-1:0]         col_inc;
    logic [bmpd_pkg::DIM_W-1:0]         row_inc;
    logic [bmpd_pkg::DIM_W-1:0]         flipped;
    logic [7:0]                         alpha;

    assign pop     = head_valid && (!valid_reg || m_tready);
    assign col_inc = {1'b0, head.col} + 1'b1;
    assign row_inc = {1'b0, head.row} + 1'b1;
    assign flipped = head.height - row_inc;
    assign pixel_y = head.bottom_up ? flipped[bmpd_pkg::COORD_W-1:0] : head.row;
    assign alpha   = head.wide ? head.last_byte : bmpd_pkg::ALPHA_OPAQUE;

    always_comb begin
        valid_next = valid_reg;
        data_next  = data_reg;
        user_next  = user_reg;
        last_next  = last_reg;
        if (pop) begin
            valid_next = 1'b1;
            user_next  = head.kind;
            data_next  = '0;
            last_next  = 1'b0;
            case (head.kind)
                bmpd_pkg::KIND_PIXEL: begin
                    data_next[15:3]  = head.width;
                    data_next[28:16] = head.height;
                    data_next[40:29] = head.col;
                    data_next[52:41] = pixel_y;
                    data_next[60:53] = head.red;
                    data_next[68:61] = head.green;
                    data_next[76:69] = head.blue;
                    data_next[84:77] = alpha;
                    last_next = (col_inc == head.width) && (row_inc == head.height);
                end
                bmpd_pkg::KIND_HEADER: begin
                    data_next[15:3]  = head.width;
                    data_next[28:16] = head.height;
                end
                bmpd_pkg::KIND_ERROR: begin
                    data_next[2:0] = head.err;
                end
                default: begin
                    data_next = '0;
                end
            endcase
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        data_reg <= data_next;
        user_reg <= user_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = user_reg;
    assign m_tlast  = last_reg;

endmodule
`default_nettype wire

@@ rtl/core/bmp_stream_to_rgba_decoder.sv @@
// a byte that completes a result is written into the result queue, then into the output
// register that raises m_tvalid
// throughput: one byte per clock while the result queue is not full, set by the per-byte parser update
// a four-entry result queue and the output register let the parser run while m_tready is low
// reset: synchronous aresetn clears parser phase, byte position, format flags,
// queue pointers and output valid; the parser then waits for the first header byte
`default_nettype none
module bmp_stream_to_rgba_decoder (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_tvalid,
    output logic                s_tready,
    input  wire logic [7:0]     s_tdata,    // data_byte
    input  wire logic           s_tlast,    // end_of_file
    output logic                m_tvalid,
    input  wire logic           m_tready,
    // error_code, image_width, image_height, pixel_x, pixel_y, red, green, blue, alpha
    output logic [87:0]         m_tdata,
    output logic [1:0]          m_tuser,    // result_kind
    output logic                m_tlast     // last_pixel
);

    bmpd_pkg::entry_t   push_entry;
    bmpd_pkg::entry_t   head;
    logic               push;
    logic               pop;
    logic               head_valid;
    logic               full;
    logic               accept;

    assign s_tready = !full;
    assign accept   = s_tvalid && !full;

    bmpd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .accept      (accept),
        .data_byte   (s_tdata),
        .end_of_file (s_tlast),
        .entry       (push_entry),
        .push        (push)
    );

    bmpd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (full)
    );

    bmpd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_valid (head_valid),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule
`default_nettype wire

@@ rtl/core/bmpd_checker.sv @@
// port-level checks on the decoder output channel
`default_nettype none
module bmpd_checker (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           m_tvalid,
    input  wire logic           m_tready,
    input  wire logic [87:0]    m_tdata,
    input  wire logic [1:0]     m_tuser,
    input  wire logic           m_tlast
);

    // a stalled result transaction holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
    else $error("output transaction changed while stalled");

    // output valid drops out of reset
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
    else $error("output valid after reset");

    // error results carry only the code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == bmpd_pkg::KIND_ERROR
            |-> m_tdata[87:3] == '0 && !m_tlast)
    else $error("error result with payload");

    // pixel coordinates fall inside the image
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == bmpd_pkg::KIND_PIXEL
            |-> {1'b0, m_tdata[40:29]} < m_tdata[15:3]
                && {1'b0, m_tdata[52:41]} < m_tdata[28:16])
    else $error("pixel outside image");

    // last flag only on pixels
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == bmpd_pkg::KIND_PIXEL)
    else $error("last flag on non-pixel result");

endmodule

bind bmp_stream_to_rgba_decoder bmpd_checker u_bmpd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
`default_nettype wire

@@ tb/bmp_stream_to_rgba_decoder_tb.sv @@
// self-checking testbench for the bmp stream to rgba decoder
module bmp_stream_to_rgba_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int PHASE_BYTES    = 40;
    localparam int HDR_BYTES      = 54;

    typedef enum logic [2:0] {
        ST_HEADER,
        ST_SKIP,
        ST_PIXELS,
        ST_PAD,
        ST_DONE,
        ST_ERROR
    } parse_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic       eof;
    } file_byte_t;

    typedef struct packed {
        bmpd_pkg::kind_t              kind;
        bmpd_pkg::err_t               err;
        logic [bmpd_pkg::DIM_W-1:0]   width;
        logic [bmpd_pkg::DIM_W-1:0]   height;
        logic [bmpd_pkg::COORD_W-1:0] px;
        logic [bmpd_pkg::COORD_W-1:0] py;
        logic [7:0]                   red;
        logic [7:0]                   green;
        logic [7:0]                   blue;
        logic [7:0]                   alpha;
        logic                         last;
    } rgba_result_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    bmp_stream_to_rgba_decoder uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    file_byte_t   byte_queue[$];
    rgba_result_t expected_results[$];
    logic [7:0]   header_bytes[HDR_BYTES];

    int bytes_queued  = 0;
    int bytes_taken   = 0;
    int mismatches    = 0;
    int quiet_cycles  = 0;
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // decoder state mirror
    parse_state_t state;
    logic [31:0]  byte_pos;
    logic [31:0]  shreg;
    logic [31:0]  data_off;
    logic [31:0]  width_r;
    logic [31:0]  height_r;
    logic [3:0]   ok_flags;
    logic         wide;
    logic         flip;
    logic [31:0]  col_cnt;
    logic [31:0]  row_cnt;
    logic [1:0]   chan_idx;
    logic [1:0]   pad_left;
    logic [23:0]  held;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    task automatic clear_parser();
        state    = ST_HEADER;
        byte_pos = '0;
        shreg    = '0;
        data_off = '0;
        width_r  = '0;
        height_r = '0;
        ok_flags = '0;
        wide     = 1'b0;
        flip     = 1'b0;
        col_cnt  = '0;
        row_cnt  = '0;
        chan_idx = '0;
        pad_left = '0;
        held     = '0;
    endtask

    task automatic end_row();
        col_cnt = '0;
        row_cnt = row_cnt + 32'd1;
        if (row_cnt == height_r) state = ST_DONE;
    endtask

    // works out the result, if any, of one accepted file byte
    task automatic decode_byte(input logic [7:0] b, input logic eof);
        rgba_result_t    r;
        logic            emit;
        logic            bad;
        bmpd_pkg::err_t  code;
        logic [31:0]     p;
        logic [15:0]     half;
        logic [1:0]      final_idx;
        logic [31:0]     dest_row;
        r    = '0;
        emit = 1'b0;
        bad  = 1'b1;
        code = bmpd_pkg::ERR_SIGNATURE;
        case (state)
            ST_HEADER: begin
                p     = byte_pos;
                shreg = {b, shreg[31:8]};
                half  = shreg[31:16];
                if (p == bmpd_pkg::POS_SIG_B && b == bmpd_pkg::CHAR_B)
                    ok_flags[bmpd_pkg::FLAG_SIG] = 1'b1;
                if (p == bmpd_pkg::POS_SIG_M && b != bmpd_pkg::CHAR_M)
                    ok_flags[bmpd_pkg::FLAG_SIG] = 1'b0;
                if (p == bmpd_pkg::POS_OFFSET) data_off = shreg;
                if (p == bmpd_pkg::POS_INFO_SIZE && shreg >= bmpd_pkg::MIN_INFO_SIZE)
                    ok_flags[bmpd_pkg::FLAG_INFO] = 1'b1;
                if (p == bmpd_pkg::POS_WIDTH) width_r = shreg;
                if (p == bmpd_pkg::POS_HEIGHT) height_r = shreg;
                if (p == bmpd_pkg::POS_PLANES && half == bmpd_pkg::ONE_PLANE)
                    ok_flags[bmpd_pkg::FLAG_PLANES] = 1'b1;
                if (p == bmpd_pkg::POS_BPP) begin
                    if (half == bmpd_pkg::BPP_24 || half == bmpd_pkg::BPP_32)
                        ok_flags[bmpd_pkg::FLAG_BPP] = 1'b1;
                    wide = (half == bmpd_pkg::BPP_32);
                end
                if (p == bmpd_pkg::POS_COMPRESSION && shreg != 0)
                    ok_flags[bmpd_pkg::FLAG_PLANES] = 1'b0;
                if (p != bmpd_pkg::POS_HEADER_END) begin
                    byte_pos = p + 32'd1;
                end else begin
                    // negative height means top-down rows
                    if (height_r[31]) begin
                        flip     = 1'b0;
                        height_r = -height_r;
                    end else begin
                        flip = 1'b1;
                    end
                    if (!ok_flags[bmpd_pkg::FLAG_SIG])
                        code = bmpd_pkg::ERR_SIGNATURE;
                    else if (!ok_flags[bmpd_pkg::FLAG_INFO])
                        code = bmpd_pkg::ERR_INFO_SIZE;
                    else if (!(ok_flags[bmpd_pkg::FLAG_PLANES] && ok_flags[bmpd_pkg::FLAG_BPP]))
                        code = bmpd_pkg::ERR_FORMAT;
                    else if (width_r == 0 || width_r[31] || height_r == 0)
                        code = bmpd_pkg::ERR_SIZE_ZERO;
                    else if (data_off < bmpd_pkg::PIXEL_START)
                        code = bmpd_pkg::ERR_OFFSET;
                    else if (width_r > bmpd_pkg::MAX_WIDTH || height_r > bmpd_pkg::MAX_HEIGHT)
                        code = bmpd_pkg::ERR_TOO_LARGE;
                    else
                        bad = 1'b0;
                    emit = 1'b1;
                    if (bad) begin
                        state  = ST_ERROR;
                        r.kind = bmpd_pkg::KIND_ERROR;
                        r.err  = code;
                    end else begin
                        r.kind   = bmpd_pkg::KIND_HEADER;
                        r.width  = width_r[bmpd_pkg::DIM_W-1:0];
                        r.height = height_r[bmpd_pkg::DIM_W-1:0];
                        byte_pos = bmpd_pkg::PIXEL_START;
                        col_cnt  = '0;
                        row_cnt  = '0;
                        chan_idx = '0;
                        pad_left = '0;
                        held     = '0;
                        state    = (data_off == bmpd_pkg::PIXEL_START) ? ST_PIXELS : ST_SKIP;
                    end
                end
            end
            ST_SKIP: begin
                byte_pos = byte_pos + 32'd1;
                if (byte_pos >= data_off) state = ST_PIXELS;
            end
            ST_PIXELS: begin
                final_idx = wide ? 2'd3 : 2'd2;
                if (chan_idx == 2'd0) held = {16'd0, b};
                else if (chan_idx < 2'd3) held[8*chan_idx +: 8] = b;
                if (chan_idx != final_idx) begin
                    chan_idx = chan_idx + 2'd1;
                end else begin
                    chan_idx = '0;
                    dest_row = flip ? (height_r - 1 - row_cnt) : row_cnt;
                    emit     = 1'b1;
                    r.kind   = bmpd_pkg::KIND_PIXEL;
                    r.width  = width_r[bmpd_pkg::DIM_W-1:0];
                    r.height = height_r[bmpd_pkg::DIM_W-1:0];
                    r.px     = col_cnt[bmpd_pkg::COORD_W-1:0];
                    r.py     = dest_row[bmpd_pkg::COORD_W-1:0];
                    r.red    = held[23:16];
                    r.green  = held[15:8];
                    r.blue   = held[7:0];
                    r.alpha  = wide ? b : bmpd_pkg::ALPHA_OPAQUE;
                    r.last   = (col_cnt + 1 == width_r) && (row_cnt + 1 == height_r);
                    col_cnt  = col_cnt + 32'd1;
                    if (col_cnt == width_r) begin
                        // 24 bpp rows are padded to a 4-byte boundary
                        if (!wide && width_r[1:0] != 2'd0) begin
                            pad_left = width_r[1:0];
                            state    = ST_PAD;
                        end else begin
                            end_row();
                        end
                    end
                end
            end
            ST_PAD: begin
                pad_left = pad_left - 2'd1;
                if (pad_left == 2'd0) begin
                    state = ST_PIXELS;
                    end_row();
                end
            end
            default: ;
        endcase
        if (eof) begin
            if (state != ST_DONE && state != ST_ERROR) begin
                r      = '0;
                r.kind = bmpd_pkg::KIND_ERROR;
                r.err  = bmpd_pkg::ERR_TRUNCATED;
                emit   = 1'b1;
            end
            clear_parser();
        end
        if (emit) expected_results.push_back(r);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    task automatic push_byte(input logic [7:0] b, input logic eof);
        file_byte_t t;
        t.data = b;
        t.eof  = eof;
        byte_queue.push_back(t);
        bytes_queued++;
    endtask

    task automatic put_le(input int pos, input logic [31:0] v, input int n);
        int i;
        for (i = 0; i < n; i++) header_bytes[pos + i] = v[8*i +: 8];
    endtask

    // a file of total bytes: header with the given fields, then random body bytes
    task automatic add_file(input logic [7:0] sig0, sig1,
                            input logic [31:0] off, info, w, h,
                            input logic [15:0] planes, bpp,
                            input logic [31:0] compr, input int total);
        int k;
        for (k = 0; k < HDR_BYTES; k++) header_bytes[k] = 8'($urandom);
        header_bytes[0] = sig0;
        header_bytes[1] = sig1;
        put_le(10, off, 4);
        put_le(14, info, 4);
        put_le(18, w, 4);
        put_le(22, h, 4);
        put_le(26, {16'd0, planes}, 2);
        put_le(28, {16'd0, bpp}, 2);
        put_le(30, compr, 4);
        for (k = 0; k < total; k++)
            push_byte((k < HDR_BYTES) ? header_bytes[k] : 8'($urandom), k == total - 1);
    endtask

    function automatic int file_length(input int w, input int habs, input int bpp,
                                       input int off);
        return off + habs * (w * bpp / 8 + ((bpp == 24) ? w % 4 : 0));
    endfunction

    // well-formed image; extra adds trailing bytes or, when negative, cuts the file short
    task automatic add_image(input int w, input int h, input int bpp, input int off,
                             input int extra);
        int habs;
        habs = (h < 0) ? -h : h;
        add_file(bmpd_pkg::CHAR_B, bmpd_pkg::CHAR_M, off, bmpd_pkg::MIN_INFO_SIZE, w, h,
                 bmpd_pkg::ONE_PLANE, 16'(bpp), 0, file_length(w, habs, bpp, off) + extra);
    endtask

    task automatic add_random_file();
        int          k, n, w, habs, bpp, off, full, total, flaw, pick;
        logic [31:0] wf, hf, info, compr;
        logic [15:0] planes, bppf;
        logic [7:0]  s0, s1;
        pick = $urandom_range(99);
        if (pick < 8) begin
            // raw noise, sometimes with early end of file
            n = $urandom_range(1, 90);
            for (k = 0; k < n; k++)
                push_byte(8'($urandom), (k == n - 1) || ($urandom_range(39) == 0));
        end else begin
            w      = ($urandom_range(9) == 0) ? $urandom_range(10, 4096) : $urandom_range(1, 9);
            habs   = ($urandom_range(9) == 0) ? $urandom_range(6, 4096) : $urandom_range(1, 5);
            bpp    = $urandom_range(1) ? 32 : 24;
            off    = ($urandom_range(3) == 0) ? 54 + $urandom_range(1, 6) : 54;
            info   = ($urandom_range(3) == 0) ? $urandom_range(41, 124)
                                              : bmpd_pkg::MIN_INFO_SIZE;
            wf     = w;
            hf     = $urandom_range(1) ? habs : -habs;
            s0     = bmpd_pkg::CHAR_B;
            s1     = bmpd_pkg::CHAR_M;
            planes = bmpd_pkg::ONE_PLANE;
            bppf   = 16'(bpp);
            compr  = 0;
            flaw   = ($urandom_range(99) < 15) ? $urandom_range(1, 12) : 0;
            case (flaw)
                1: begin
                    s0 = 8'($urandom);
                    if (s0 == bmpd_pkg::CHAR_B) s0 = bmpd_pkg::CHAR_M;
                end
                2: begin
                    s1 = 8'($urandom);
                    if (s1 == bmpd_pkg::CHAR_M) s1 = bmpd_pkg::CHAR_B;
                end
                3: info = $urandom_range(0, 39);
                4: begin
                    planes = 16'($urandom);
                    if (planes == bmpd_pkg::ONE_PLANE) planes = 16'd0;
                end
                5: begin
                    bppf = 16'($urandom_range(0, 64));
                    if (bppf == bmpd_pkg::BPP_24 || bppf == bmpd_pkg::BPP_32) bppf = 16'd16;
                end
                6: compr = 32'($urandom) | 32'd1;
                7: wf = 0;
                8: wf = 32'($urandom) | 32'h8000_0000;
                9: hf = 0;
                10: off = $urandom_range(0, 53);
                11: wf = $urandom_range(4097, 65535);
                12: hf = $urandom_range(1) ? 32'h8000_0000 : 32'($urandom_range(4097, 65535));
                default: ;
            endcase
            full = file_length(w, habs, bpp, off);
            if (flaw != 0) total = HDR_BYTES + $urandom_range(0, 6);
            else if (full > 300) total = $urandom_range(HDR_BYTES, 300);
            else begin
                pick = $urandom_range(99);
                if (pick < 70) total = full;
                else if (pick < 80) total = full + $urandom_range(1, 8);
                else total = $urandom_range(1, full - 1);
            end
            add_file(s0, s1, off, info, wf, hf, planes, bppf, compr, total);
        end
    endtask

    task automatic drain();
        while (bytes_taken != bytes_queued || expected_results.size() != 0) @(posedge aclk);
    endtask

    // input side: one file byte per transaction
    always @(posedge aclk) begin : byte_driver
        file_byte_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                decode_byte(s_tdata, s_tlast);
                bytes_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    nxt = byte_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.data;
                    s_tlast  <= nxt.eof;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge aclk) begin : result_monitor
        rgba_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result, expected none, actual kind %0d",
                         $time, m_tuser);
            end else begin
                want = expected_results.pop_front();
                check_field("result_kind", want.kind, m_tuser);
                check_field("error_code", want.err, m_tdata[2:0]);
                check_field("image_width", want.width, m_tdata[15:3]);
                check_field("image_height", want.height, m_tdata[28:16]);
                check_field("pixel_x", want.px, m_tdata[40:29]);
                check_field("pixel_y", want.py, m_tdata[52:41]);
                check_field("red", want.red, m_tdata[60:53]);
                check_field("green", want.green, m_tdata[68:61]);
                check_field("blue", want.blue, m_tdata[76:69]);
                check_field("alpha", want.alpha, m_tdata[84:77]);
                check_field("tdata padding", 0, m_tdata[87:85]);
                check_field("last_pixel", want.last, m_tlast);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        int ph, goal;
        clear_parser();
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // complete images: padding, skip bytes, flip, alpha, trailing bytes
        add_image(1, 1, 24, 54, 0);
        add_image(2, -2, 32, 54, 0);
        add_image(3, 2, 24, 57, 0);
        add_image(4, 1, 24, 54, 0);
        add_image(1, 2, 32, 54, 5);
        // truncated in final padding, mid pixel, and in the skip area
        add_image(3, 1, 24, 54, -1);
        add_image(2, 2, 24, 54, -7);
        add_image(5, 3, 24, 60, -(file_length(5, 3, 24, 60) - 56));
        // widest row cut after three pixels, tallest image cut after two pixels
        add_image(4096, 1, 24, 54, -(4096 * 3 - 9));
        add_image(1, 4096, 32, 54, -(4096 * 4 - 8));
        // header rejections in check order, end of file on the checked byte
        add_file(bmpd_pkg::CHAR_M, bmpd_pkg::CHAR_M, 54, 40, 2, 2,
                 bmpd_pkg::ONE_PLANE, bmpd_pkg::BPP_24, 0, HDR_BYTES);
        add_file(bmpd_pkg::CHAR_B, bmpd_pkg::CHAR_B, 54, 40, 2, 2,
                 bmpd_pkg::ONE_PLANE, bmpd_pkg::BPP_24, 0, HDR_BYTES);
        add_file(bmpd_pkg::CHAR_B, bmpd_pkg::CHAR_M, 54, 39, 2, 2,
                 bmpd_pkg::ONE_PLANE, bmpd_pkg::BPP_24, 0, HDR_BYTES);
        add_file(bmpd_pkg::CHAR_B, bmpd_pkg::CHAR_M, 54, 40, 2, 2,
                 16'd2, bmpd_pkg::BPP_24, 0, HDR_BYTES);
        add_file(bmpd_pkg::CHAR_B, bmpd_pkg::CHAR_M, 54, 40, 2, 2,
                 bmpd_pkg::ONE_PLANE, 16'd16, 0, HDR_BYTES);
        add_file(bmpd_pkg::CHAR_B, bmpd_pkg::CHAR_M, 54, 40, 2, 2,
                 bmpd_pkg::ONE_PLANE, bmpd_pkg::BPP_32, 1, HDR_BYTES);
        add_file(bmpd_pkg::CHAR_B, bmpd_pkg::CHAR_M, 54, 40, 0, 2,
                 bmpd_pkg::ONE_PLANE, bmpd_pkg::BPP_24, 0, HDR_BYTES);
        add_file(bmpd_pkg::CHAR_B, bmpd_pkg::CHAR_M, 54, 40, 32'h8000_0001, 2,
                 bmpd_pkg::ONE_PLANE, bmpd_pkg::BPP_24, 0, HDR_BYTES);
        add_file(bmpd_pkg::CHAR_B, bmpd_pkg::CHAR_M, 54, 40, 2, 0,
                 bmpd_pkg::ONE_PLANE, bmpd_pkg::BPP_24, 0, HDR_BYTES);
        add_file(bmpd_pkg::CHAR_B, bmpd_pkg::CHAR_M, 53, 40, 2, 2,
                 bmpd_pkg::ONE_PLANE, bmpd_pkg::BPP_24, 0, HDR_BYTES);
        add_file(bmpd_pkg::CHAR_B, bmpd_pkg::CHAR_M, 54, 40, 4097, 2,
                 bmpd_pkg::ONE_PLANE, bmpd_pkg::BPP_24, 0, HDR_BYTES);
        add_file(bmpd_pkg::CHAR_B, bmpd_pkg::CHAR_M, 54, 40, 2, -4097,
                 bmpd_pkg::ONE_PLANE, bmpd_pkg::BPP_24, 0, HDR_BYTES);
        add_file(bmpd_pkg::CHAR_B, bmpd_pkg::CHAR_M, 54, 40, 2, 32'h8000_0000,
                 bmpd_pkg::ONE_PLANE, bmpd_pkg::BPP_24, 0, HDR_BYTES);
        // end of file inside the header, and on the final byte of a good header
        add_file(bmpd_pkg::CHAR_B, bmpd_pkg::CHAR_M, 54, 40, 2, 2,
                 bmpd_pkg::ONE_PLANE, bmpd_pkg::BPP_24, 0, 20);
        add_file(bmpd_pkg::CHAR_B, bmpd_pkg::CHAR_M, 54, 40, 2, 2,
                 bmpd_pkg::ONE_PLANE, bmpd_pkg::BPP_24, 0, HDR_BYTES);

        for (ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 79; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 79; end
                default: begin send_idle_pct = 28; stall_pct = 28; end
            endcase
            // the directed files make up the no-idle phase
            goal = bytes_queued + ((ph == 0) ? 0 : PHASE_BYTES);
            while (bytes_queued < goal) add_random_file();
            // sender holds off until every result of this phase is back
            drain();
        end

        repeat (20) @(posedge aclk);
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/bmpd_pkg.sv
rtl/core/bmpd_front.sv
rtl/core/bmpd_queue.sv
rtl/core/bmpd_back.sv
rtl/core/bmp_stream_to_rgba_decoder.sv
rtl/core/bmpd_checker.sv
tb/bmp_stream_to_rgba_decoder_tb.sv
